### rtl/inverted_pendulum_step_top_macros.svh
// Assertion macros for the pendulum step block.
// Included by the top level; needs nothing else.
`ifndef INVERTED_PENDULUM_STEP_TOP_MACROS_SVH
`define INVERTED_PENDULUM_STEP_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset
`define IPS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ips assertion failed");

// Next-cycle implication, disabled during reset
`define IPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ips assertion failed");

`endif

### rtl/ips_pkg.sv
// Shared types, codes and constants of the pendulum step block.
// No dependencies.
package ips_pkg;

    // Configuration register indexes
    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] REG_INV_LENGTH = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GRAVITY    = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_GAIN = 8'd3;

    // Register reset values
    localparam logic [31:0] INV_LENGTH_RST = 32'd14316558;
    localparam logic [31:0] TIME_STEP_RST  = 32'd71582788;
    localparam logic [15:0] GRAVITY_RST    = 16'd9810;
    localparam logic [15:0] ACCEL_GAIN_RST = 16'd1000;

    // Fixed-point constants (angle Q6.26, position Q16.16, sin/cos Q2.30)
    localparam logic signed [31:0] Q_PI        = 32'sd210828714;
    localparam logic signed [31:0] Q_TWO_PI    = 32'sd421657428;
    localparam logic signed [31:0] Q_HALF_PI   = 32'sd105414357;
    localparam logic signed [63:0] UP_LOW      = 64'sd105411248;
    localparam logic signed [63:0] UP_HIGH     = 64'sd316233744;
    localparam logic signed [31:0] ANGLE_RST   = 32'sd6588396;
    localparam logic signed [31:0] POS_RST     = 32'sd26214400;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
    localparam int CORDIC_STEPS = 16;
    localparam int CS_W = 34;

    // Reciprocal of 2*pi for the angle reduction: floor(2^60 / Q_TWO_PI)
    localparam int RED_SHIFT = 60;
    localparam logic [31:0] RED_RECIP = 32'((64'd1 << RED_SHIFT) / 64'(Q_TWO_PI));

    // Serial multiplier sizes: |a| up to 48 bits, |b| up to 32 bits
    localparam int MUL_A_W = 48;
    localparam int MUL_B_W = 32;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    typedef enum logic [2:0] {
        S_IDLE, S_VEL, S_POS, S_COR_START, S_COR_WAIT, S_MUL_START, S_MUL_WAIT, S_OUT
    } t_state;

    typedef enum logic [3:0] {
        M_RED, M_QC, M_AXG, M_KA, M_AYG, M_KB, M_KG, M_SKG, M_CKA, M_SKB, M_ADT, M_RDT
    } t_mop;

    typedef enum logic [1:0] {
        C_IDLE, C_FOLD, C_ITER
    } t_cor_state;

    typedef struct packed {
        logic               start;
        logic signed [63:0] a;
        logic signed [63:0] b;
        logic [5:0]         shift;
    } t_mul_req;

    typedef struct packed {
        logic               done;
        logic signed [63:0] p;
    } t_mul_rsp;

    // CORDIC arctangent table, Q2.30
    function automatic logic signed [CS_W-1:0] atan_entry(input logic [3:0] idx);
        logic signed [CS_W-1:0] v;
        case (idx)
            4'd0:    v = 34'sd843314857;
            4'd1:    v = 34'sd497837829;
            4'd2:    v = 34'sd263043837;
            4'd3:    v = 34'sd133525159;
            4'd4:    v = 34'sd67021687;
            4'd5:    v = 34'sd33543516;
            4'd6:    v = 34'sd16775851;
            4'd7:    v = 34'sd8388437;
            4'd8:    v = 34'sd4194283;
            4'd9:    v = 34'sd2097149;
            4'd10:   v = 34'sd1048575;
            4'd11:   v = 34'sd524287;
            4'd12:   v = 34'sd262143;
            4'd13:   v = 34'sd131071;
            4'd14:   v = 34'sd65535;
            default: v = 34'sd32767;
        endcase
        return v;
    endfunction

endpackage

### rtl/ips_if.sv
// Channel interfaces of the pendulum step block: input, result, configuration.
// Depends on ips_pkg.
interface ips_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] accel_x;
    logic signed [31:0] accel_y;
    logic               restart;
    modport source (output valid, accel_x, accel_y, restart, input ready);
    modport sink   (input valid, accel_x, accel_y, restart, output ready);
endinterface

interface ips_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] anchor_x;
    logic signed [31:0] anchor_y;
    logic signed [31:0] angle_out;
    logic signed [31:0] rate_out;
    logic signed [31:0] angular_accel;
    logic               upright;
    logic [30:0]        tilt_magnitude;
    modport source (output valid, anchor_x, anchor_y, angle_out, rate_out, angular_accel,
                    upright, tilt_magnitude, input ready);
    modport sink   (input valid, anchor_x, anchor_y, angle_out, rate_out, angular_accel,
                    upright, tilt_magnitude, output ready);
endinterface

interface ips_cfg_if import ips_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [31:0]          data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### rtl/inverted_pendulum_step_top.sv
// Top level of the pendulum step block: sequencer, state and configuration.
// Depends on ips_pkg, ips_if, ips_mul, ips_cordic and the macros header.
//
// Use: one transaction on i_in is one simulation tick (anchor acceleration,
// restart flag); it yields exactly one transaction on o_out. Configuration
// writes on i_cfg (index 0..3: inv_length, time_step, gravity_scaled,
// accel_gain) are always ready; other indexes are ignored.
// A tick runs twelve products through the shared bit-serial multiplier (start,
// 32 add-shift steps, sign and shift, handoff); the first two reduce the angle
// modulo 2*pi for the CORDIC (start, fold, 16 steps, handoff). There are also
// steps for accept, velocity, position and output load. A restart tick goes
// from accept straight to output load.
// i_in.ready is high only while no tick is being worked on.
// Results sit in an output register; if the receiver stalls, the next tick is
// still accepted and computed, and it waits in its last step until the
// register frees up. Reset (i_rst_n low, synchronous) loads the register
// defaults and the initial pendulum state and empties the output.
`include "inverted_pendulum_step_top_macros.svh"

module inverted_pendulum_step_top import ips_pkg::*; #(
    parameter int WORD_WIDTH = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    ips_in_if.sink    i_in,
    ips_cfg_if.sink   i_cfg,
    ips_out_if.source o_out
);

    localparam int W  = WORD_WIDTH;
    localparam int PW = (W > 32) ? W : 32;
    localparam logic signed [63:0] W_MAX = (64'sd1 <<< (W - 1)) - 64'sd1;
    localparam logic signed [63:0] W_MIN = -W_MAX - 64'sd1;

    // Saturate to the signed W-bit range
    function automatic logic signed [W-1:0] sat_w(input logic signed [63:0] v);
        logic signed [63:0] r;
        r = v;
        if (v > W_MAX) r = W_MAX;
        if (v < W_MIN) r = W_MIN;
        return r[W-1:0];
    endfunction

    // Saturate to the signed 32-bit range
    function automatic logic signed [31:0] sat_32(input logic signed [63:0] v);
        logic signed [63:0] r;
        r = v;
        if (v > 64'sd2147483647) r = 64'sd2147483647;
        if (v < -64'sd2147483648) r = -64'sd2147483648;
        return r[31:0];
    endfunction

    t_state r_state, n_state;
    t_mop   r_op;

    logic [31:0] r_il, r_dt;
    logic [15:0] r_grav, r_gain;

    logic signed [PW-1:0] r_pos_x, r_pos_y;
    logic signed [W-1:0]  r_vel_x, r_vel_y, r_angle, r_rate;
    logic signed [31:0]   r_ax, r_ay, r_alpha, r_red;
    logic signed [63:0]   r_tmp, r_ka, r_kb, r_kg, r_acc;
    logic signed [CS_W-1:0] r_sin, r_cos;

    logic               r_ov;
    logic signed [31:0] r_o_ax, r_o_ay, r_o_ang, r_o_rate, r_o_alpha;
    logic               r_o_up;
    logic [30:0]        r_o_tilt;

    t_mul_req mul_req;
    t_mul_rsp mul_rsp;
    logic     cor_start, cor_done;
    logic signed [CS_W-1:0] cor_sin, cor_cos;

    logic signed [W-1:0]  vx_n, vy_n, px_w, py_w;
    logic signed [63:0]   ang64, mag64, acc_n;
    logic signed [63:0]   red_rem, red_fix, red_val;
    logic                 out_load;

    ips_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_rsp   (mul_rsp)
    );

    ips_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cor_start),
        .i_angle (r_red),
        .o_done  (cor_done),
        .o_sin   (cor_sin),
        .o_cos   (cor_cos)
    );

    // Sequencer state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and unit controls
    always_comb begin
        n_state   = r_state;
        cor_start = 1'b0;
        out_load  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in.valid) n_state = i_in.restart ? S_OUT : S_VEL;
            end
            S_VEL:       n_state = S_POS;
            S_POS:       n_state = S_MUL_START;
            S_COR_START: begin
                cor_start = 1'b1;
                n_state   = S_COR_WAIT;
            end
            S_COR_WAIT:  if (cor_done) n_state = S_MUL_START;
            S_MUL_START: n_state = S_MUL_WAIT;
            S_MUL_WAIT: begin
                if (mul_rsp.done) begin
                    if (r_op == M_QC) begin
                        n_state = S_COR_START;
                    end else if (r_op == M_RDT) begin
                        n_state = S_OUT;
                    end else begin
                        n_state = S_MUL_START;
                    end
                end
            end
            S_OUT: begin
                if (!r_ov || o_out.ready) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Multiplier start and operand selection
    always_comb begin
        mul_req.start = (r_state == S_MUL_START);
        mul_req.a     = 64'(r_ax);
        mul_req.b     = {48'd0, r_gain};
        mul_req.shift = 6'd0;
        case (r_op)
            M_RED: begin
                mul_req.a = mag64; mul_req.b = {32'd0, RED_RECIP};
                mul_req.shift = 6'(RED_SHIFT);
            end
            M_QC: begin
                mul_req.a = r_tmp; mul_req.b = 64'(Q_TWO_PI); mul_req.shift = 6'd0;
            end
            M_AXG: begin
                mul_req.a = 64'(r_ax); mul_req.b = {48'd0, r_gain}; mul_req.shift = 6'd0;
            end
            M_KA: begin
                mul_req.a = r_tmp; mul_req.b = {32'd0, r_il}; mul_req.shift = 6'd32;
            end
            M_AYG: begin
                mul_req.a = 64'(r_ay); mul_req.b = {48'd0, r_gain}; mul_req.shift = 6'd0;
            end
            M_KB: begin
                mul_req.a = r_tmp; mul_req.b = {32'd0, r_il}; mul_req.shift = 6'd32;
            end
            M_KG: begin
                mul_req.a = {48'd0, r_grav}; mul_req.b = {32'd0, r_il}; mul_req.shift = 6'd16;
            end
            M_SKG: begin
                mul_req.a = 64'(r_sin); mul_req.b = {32'd0, r_kg[31:0]};
                mul_req.shift = 6'd30;
            end
            M_CKA: begin
                mul_req.a = r_ka; mul_req.b = 64'(r_cos); mul_req.shift = 6'd30;
            end
            M_SKB: begin
                mul_req.a = r_kb; mul_req.b = 64'(r_sin); mul_req.shift = 6'd30;
            end
            M_ADT: begin
                mul_req.a = 64'(r_alpha); mul_req.b = {32'd0, r_dt}; mul_req.shift = 6'd32;
            end
            M_RDT: begin
                mul_req.a = 64'(r_rate); mul_req.b = {32'd0, r_dt}; mul_req.shift = 6'd22;
            end
            default: ;
        endcase
    end

    // Anchor update, angle remainder, output view of the angle
    always_comb begin
        vx_n  = r_vel_x - (r_vel_x >>> 5) + W'(r_ax);
        vy_n  = r_vel_y - (r_vel_y >>> 5) + W'(r_ay);
        px_w  = r_pos_x[W-1:0] + r_vel_x;
        py_w  = r_pos_y[W-1:0] + r_vel_y;
        acc_n = r_acc - mul_rsp.p;
        ang64 = 64'(r_angle);
        mag64 = ang64[63] ? -ang64 : ang64;
        // quotient estimate is exact or one low: one correction step
        red_rem = mag64 - mul_rsp.p;
        red_fix = (red_rem >= 64'(Q_TWO_PI)) ? red_rem - 64'(Q_TWO_PI) : red_rem;
        red_val = ang64[63] ? -red_fix : red_fix;
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_il   <= INV_LENGTH_RST;
            r_dt   <= TIME_STEP_RST;
            r_grav <= GRAVITY_RST;
            r_gain <= ACCEL_GAIN_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_INV_LENGTH: r_il   <= i_cfg.data;
                REG_TIME_STEP:  r_dt   <= i_cfg.data;
                REG_GRAVITY:    r_grav <= i_cfg.data[15:0];
                REG_ACCEL_GAIN: r_gain <= i_cfg.data[15:0];
                default: ;
            endcase
        end
    end

    // Pendulum state and working registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x <= PW'(POS_RST);
            r_pos_y <= PW'(POS_RST);
            r_vel_x <= '0;
            r_vel_y <= '0;
            r_angle <= W'(ANGLE_RST);
            r_rate  <= '0;
            r_alpha <= '0;
            r_op    <= M_RED;
        end else begin
            case (r_state)
                S_IDLE: begin
                    r_ax <= i_in.accel_x;
                    r_ay <= i_in.accel_y;
                    r_op <= M_RED;
                    if (i_in.valid && i_in.restart) begin
                        r_pos_x <= PW'(POS_RST);
                        r_pos_y <= PW'(POS_RST);
                        r_vel_x <= '0;
                        r_vel_y <= '0;
                        r_angle <= W'(ANGLE_RST);
                        r_rate  <= '0;
                        r_alpha <= '0;
                    end
                end
                S_VEL: begin
                    r_vel_x <= vx_n;
                    r_vel_y <= vy_n;
                end
                S_POS: begin
                    r_pos_x <= PW'(px_w);
                    r_pos_y <= PW'(py_w);
                end
                S_COR_WAIT: begin
                    if (cor_done) begin
                        r_sin <= cor_sin;
                        r_cos <= cor_cos;
                    end
                end
                S_MUL_WAIT: begin
                    if (mul_rsp.done) begin
                        case (r_op)
                            M_RED: r_tmp <= mul_rsp.p;
                            M_QC:  r_red <= red_val[31:0];
                            M_AXG, M_AYG: r_tmp <= mul_rsp.p;
                            M_KA:  r_ka  <= mul_rsp.p;
                            M_KB:  r_kb  <= mul_rsp.p;
                            M_KG:  r_kg  <= mul_rsp.p;
                            M_SKG: r_acc <= mul_rsp.p;
                            M_CKA: r_acc <= acc_n;
                            M_SKB: r_alpha <= sat_32(acc_n);
                            M_ADT: r_rate  <= sat_w(64'(r_rate) + mul_rsp.p);
                            M_RDT: r_angle <= sat_w(64'(r_angle) + mul_rsp.p);
                            default: ;
                        endcase
                        if (r_op != M_RDT) r_op <= t_mop'(r_op + 4'd1);
                    end
                end
                default: ;
            endcase
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (out_load) begin
            r_ov      <= 1'b1;
            r_o_ax    <= r_pos_x[31:0];
            r_o_ay    <= r_pos_y[31:0];
            r_o_ang   <= ang64[31:0];
            r_o_rate  <= 32'(r_rate);
            r_o_alpha <= r_alpha;
            r_o_up    <= (ang64 < UP_LOW) || (ang64 > UP_HIGH);
            r_o_tilt  <= (mag64 > 64'sd2147483647) ? 31'h7FFFFFFF : mag64[30:0];
        end else if (o_out.ready) begin
            r_ov <= 1'b0;
        end
    end

    assign i_in.ready           = (r_state == S_IDLE);
    assign i_cfg.ready          = 1'b1;
    assign o_out.valid          = r_ov;
    assign o_out.anchor_x       = r_o_ax;
    assign o_out.anchor_y       = r_o_ay;
    assign o_out.angle_out      = r_o_ang;
    assign o_out.rate_out       = r_o_rate;
    assign o_out.angular_accel  = r_o_alpha;
    assign o_out.upright        = r_o_up;
    assign o_out.tilt_magnitude = r_o_tilt;

    // A tick in progress blocks further input
    `IPS_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in.valid && i_in.ready && !i_in.restart, !i_in.ready)
    // Product results arrive only while the sequencer waits for them
    `IPS_ASSERT_IMPL(a_mul_done_in_wait, i_clk, i_rst_n, mul_rsp.done, r_state == S_MUL_WAIT)
    // CORDIC results arrive only while the sequencer waits for them
    `IPS_ASSERT_IMPL(a_cor_done_in_wait, i_clk, i_rst_n, cor_done, r_state == S_COR_WAIT)

endmodule

### rtl/ips_mul.sv
// Bit-serial signed multiplier: floor(a*b / 2^shift), one partial product a cycle.
// Depends on ips_pkg.
module ips_mul import ips_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_mul_req i_req,
    output t_mul_rsp o_rsp
);

    logic               r_busy, r_fin, r_done, r_neg;
    logic [4:0]         r_cnt;
    logic [MUL_P_W-1:0] r_acc, r_ma;
    logic [MUL_B_W-1:0] r_mb;
    logic [5:0]         r_shift;
    logic signed [63:0] r_p;

    logic [63:0]          ua, ub;
    logic signed [MUL_P_W:0] sp, sh;

    // Operand magnitudes and final signed, floored product
    always_comb begin
        ua = i_req.a[63] ? (~i_req.a + 64'd1) : i_req.a;
        ub = i_req.b[63] ? (~i_req.b + 64'd1) : i_req.b;
        sp = r_neg ? -$signed({1'b0, r_acc}) : $signed({1'b0, r_acc});
        sh = sp >>> r_shift;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            r_fin  <= 1'b0;
            if (i_req.start) begin
                r_busy  <= 1'b1;
                r_cnt   <= '0;
                r_acc   <= '0;
                r_ma    <= {{MUL_B_W{1'b0}}, ua[MUL_A_W-1:0]};
                r_mb    <= ub[MUL_B_W-1:0];
                r_neg   <= i_req.a[63] ^ i_req.b[63];
                r_shift <= i_req.shift;
            end else if (r_busy) begin
                if (r_mb[0]) begin
                    r_acc <= r_acc + r_ma;
                end
                r_ma  <= r_ma << 1;
                r_mb  <= r_mb >> 1;
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end else if (r_fin) begin
                r_p    <= sh[63:0];
                r_done <= 1'b1;
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.p    = r_p;

endmodule

### rtl/ips_cordic.sv
// Quadrant fold and 16-step CORDIC sin/cos of an angle already reduced modulo 2*pi.
// Depends on ips_pkg.
module ips_cordic import ips_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic signed [31:0]     i_angle,
    output logic                   o_done,
    output logic signed [CS_W-1:0] o_sin,
    output logic signed [CS_W-1:0] o_cos
);

    t_cor_state r_state, n_state;
    logic [3:0]             r_i;
    logic                   r_flip, r_done;
    logic signed [CS_W-1:0] r_x, r_y, r_z;

    logic signed [31:0]  r1, r2, rf;
    logic                fl;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            C_IDLE: if (i_start) n_state = C_FOLD;
            C_FOLD: n_state = C_ITER;
            C_ITER: if (r_i == 4'(CORDIC_STEPS - 1)) n_state = C_IDLE;
            default: n_state = C_IDLE;
        endcase
    end

    // Bring the angle into [-pi, pi], then fold into [-pi/2, pi/2]
    always_comb begin
        r1 = (i_angle > Q_PI) ? i_angle - Q_TWO_PI : i_angle;
        r2 = (r1 < -Q_PI) ? r1 + Q_TWO_PI : r1;
        fl = 1'b0;
        rf = r2;
        if (r2 > Q_HALF_PI) begin
            rf = Q_PI - r2;
            fl = 1'b1;
        end else if (r2 < -Q_HALF_PI) begin
            rf = -Q_PI - r2;
            fl = 1'b1;
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                C_FOLD: begin
                    r_flip <= fl;
                    r_z    <= {rf[29:0], 4'b0000};
                    r_x    <= CORDIC_GAIN;
                    r_y    <= '0;
                    r_i    <= '0;
                end
                C_ITER: begin
                    if (!r_z[CS_W-1]) begin
                        r_x <= r_x - (r_y >>> r_i);
                        r_y <= r_y + (r_x >>> r_i);
                        r_z <= r_z - atan_entry(r_i);
                    end else begin
                        r_x <= r_x + (r_y >>> r_i);
                        r_y <= r_y - (r_x >>> r_i);
                        r_z <= r_z + atan_entry(r_i);
                    end
                    r_i <= r_i + 4'd1;
                    if (r_i == 4'(CORDIC_STEPS - 1)) r_done <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_sin  = r_y;
    assign o_cos  = r_flip ? -r_x : r_x;

endmodule

### tb/inverted_pendulum_step_top_test.sv
// Self-checking testbench of the pendulum step block: directed and random ticks
// through the input channel, results checked against a cycle-free tick model.
// Depends on ips_pkg, ips_if and the inverted_pendulum_step_top RTL.
module inverted_pendulum_step_top_test;
    import ips_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 8'd7;
    localparam int TICK_CYCLES = 450;
    localparam int PRESSURE_CYCLES = 3000;

    typedef struct {
        logic signed [31:0] accel_x;
        logic signed [31:0] accel_y;
        logic               restart;
    } t_tick_in;

    typedef struct {
        logic signed [31:0] anchor_x;
        logic signed [31:0] anchor_y;
        logic signed [31:0] angle_out;
        logic signed [31:0] rate_out;
        logic signed [31:0] angular_accel;
        logic               upright;
        logic [30:0]        tilt_magnitude;
    } t_tick_out;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    ips_in_if  in_ch ();
    ips_out_if out_ch ();
    ips_cfg_if cfg_ch ();

    inverted_pendulum_step_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .i_cfg   (cfg_ch),
        .o_out   (out_ch)
    );

    always #5 i_clk = ~i_clk;

    t_tick_in  tick_pending_q[$];
    t_tick_out tick_expect_q[$];
    int        fail_count = 0;
    int        mismatch_count = 0;
    logic      steady_flow = 1'b0;
    logic      pressure_go = 1'b0;

    // Model copy of the registers and the pendulum state
    longint cfg_inv_length, cfg_time_step, cfg_gravity, cfg_gain;
    longint pos_x, pos_y, vel_x, vel_y, angle, ang_rate;

    longint atan_lut [0:15] = '{
        843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
        16775851, 8388437, 4194283, 2097149, 1048575, 524287, 262143,
        131071, 65535, 32767
    };

    function automatic longint wrap32(longint v);
        return longint'(signed'(v[31:0]));
    endfunction

    function automatic longint sat32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // floor(a*b / 2^s), clamped to 64 bits
    function automatic longint fixed_mul(longint a, longint b, int s);
        logic signed [127:0] pa, pb, q;
        pa = a;
        pb = b;
        q = (pa * pb) >>> s;
        if (q[127:63] != {65{q[127]}})
            return q[127] ? 64'sh8000000000000000 : 64'sh7fffffffffffffff;
        return longint'(q[63:0]);
    endfunction

    // Quadrant fold then 16 rotation steps; sin/cos in Q2.30
    task automatic pendulum_sincos(input longint th, output longint sn, output longint cs);
        longint r, x, y, z, nx;
        bit flip;
        r = th % longint'(Q_TWO_PI);
        flip = 1'b0;
        if (r > longint'(Q_PI)) r -= longint'(Q_TWO_PI);
        if (r < -longint'(Q_PI)) r += longint'(Q_TWO_PI);
        if (r > longint'(Q_HALF_PI)) begin
            r = longint'(Q_PI) - r;
            flip = 1'b1;
        end else if (r < -longint'(Q_HALF_PI)) begin
            r = -longint'(Q_PI) - r;
            flip = 1'b1;
        end
        x = longint'(CORDIC_GAIN);
        y = 0;
        z = r * 16;
        for (int i = 0; i < 16; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                z -= atan_lut[i];
            end else begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                z += atan_lut[i];
            end
            x = nx;
        end
        sn = y;
        cs = flip ? -x : x;
    endtask

    task automatic reload_pendulum();
        pos_x = longint'(POS_RST);
        pos_y = longint'(POS_RST);
        vel_x = 0;
        vel_y = 0;
        angle = longint'(ANGLE_RST);
        ang_rate = 0;
    endtask

    // One Euler tick of the model
    task automatic predict_tick(input t_tick_in t, output t_tick_out r);
        longint ax, ay, sn, cs, ka, kb, kg, alpha, mag;
        alpha = 0;
        if (t.restart) begin
            reload_pendulum();
        end else begin
            ax = longint'(t.accel_x);
            ay = longint'(t.accel_y);
            vel_x = wrap32(vel_x - (vel_x >>> 5) + ax);
            vel_y = wrap32(vel_y - (vel_y >>> 5) + ay);
            pos_x = wrap32(pos_x + vel_x);
            pos_y = wrap32(pos_y + vel_y);
            pendulum_sincos(angle, sn, cs);
            ka = fixed_mul(ax * cfg_gain, cfg_inv_length, 32);
            kb = fixed_mul(ay * cfg_gain, cfg_inv_length, 32);
            kg = (cfg_gravity * cfg_inv_length) >>> 16;
            alpha = fixed_mul(sn, kg, 30) - fixed_mul(cs, ka, 30) - fixed_mul(sn, kb, 30);
            alpha = sat32(alpha);
            ang_rate = sat32(ang_rate + fixed_mul(alpha, cfg_time_step, 32));
            angle = sat32(angle + fixed_mul(ang_rate, cfg_time_step, 22));
        end
        mag = angle < 0 ? -angle : angle;
        if (mag > 64'sd2147483647) mag = 64'sd2147483647;
        r.anchor_x = pos_x[31:0];
        r.anchor_y = pos_y[31:0];
        r.angle_out = angle[31:0];
        r.rate_out = ang_rate[31:0];
        r.angular_accel = alpha[31:0];
        r.upright = (angle < longint'(UP_LOW) || angle > longint'(UP_HIGH));
        r.tilt_magnitude = mag[30:0];
    endtask

    function automatic int random_gap();
        if ($urandom_range(0, 9) < 8) return $urandom_range(0, 3);
        return $urandom_range(10, 80);
    endfunction

    // Start values before the first edge
    initial begin
        in_ch.valid = 1'b0;
        in_ch.accel_x = '0;
        in_ch.accel_y = '0;
        in_ch.restart = 1'b0;
        out_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
    end

    // Input driver: pops pending ticks, random gaps between transactions
    int send_gap = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (in_ch.valid && !in_ch.ready) begin
            // hold the offered tick
        end else if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            in_ch.valid <= 1'b0;
        end else if (tick_pending_q.size() > 0) begin
            t_tick_in t;
            t = tick_pending_q.pop_front();
            in_ch.accel_x <= t.accel_x;
            in_ch.accel_y <= t.accel_y;
            in_ch.restart <= t.restart;
            in_ch.valid <= 1'b1;
            send_gap <= steady_flow ? 0 : random_gap();
        end else begin
            in_ch.valid <= 1'b0;
        end
    end

    // Result receiver: random stalls plus one long hold-off
    int  stall_left = 0;
    bit  pressure_used = 1'b0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else if (pressure_go && !pressure_used) begin
            pressure_used <= 1'b1;
            stall_left <= PRESSURE_CYCLES;
            out_ch.ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            out_ch.ready <= 1'b0;
        end else if (steady_flow || $urandom_range(0, 3) != 0) begin
            out_ch.ready <= 1'b1;
        end else begin
            stall_left <= random_gap();
            out_ch.ready <= 1'b0;
        end
    end

    // Predict on each accepted input transaction
    always @(posedge i_clk) begin
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            t_tick_in t;
            t_tick_out r;
            t.accel_x = in_ch.accel_x;
            t.accel_y = in_ch.accel_y;
            t.restart = in_ch.restart;
            predict_tick(t, r);
            tick_expect_q.insert(tick_expect_q.size(), r);
        end
    end

    // Check each accepted result transaction against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (tick_expect_q.size() == 0) begin
                fail_count++;
                $display("unexpected result transaction at %0t", $realtime);
            end else begin
                t_tick_out e;
                e = tick_expect_q.pop_front();
                if (e.anchor_x !== out_ch.anchor_x || e.anchor_y !== out_ch.anchor_y ||
                    e.angle_out !== out_ch.angle_out || e.rate_out !== out_ch.rate_out ||
                    e.angular_accel !== out_ch.angular_accel ||
                    e.upright !== out_ch.upright ||
                    e.tilt_magnitude !== out_ch.tilt_magnitude) begin
                    fail_count++;
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("mismatch at %0t: exp x=%h y=%h ang=%h rate=%h acc=%h up=%b mag=%h",
                                 $realtime, e.anchor_x, e.anchor_y, e.angle_out, e.rate_out,
                                 e.angular_accel, e.upright, e.tilt_magnitude);
                        $display("                 got x=%h y=%h ang=%h rate=%h acc=%h up=%b mag=%h",
                                 out_ch.anchor_x, out_ch.anchor_y, out_ch.angle_out,
                                 out_ch.rate_out, out_ch.angular_accel, out_ch.upright,
                                 out_ch.tilt_magnitude);
                    end
                end
            end
        end
    end

    // Register write; called at a rising edge, leaves valid high
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        cfg_ch.index <= idx;
        cfg_ch.data <= val;
        cfg_ch.valid <= 1'b1;
        do @(posedge i_clk); while (!cfg_ch.ready);
        case (idx)
            REG_INV_LENGTH: cfg_inv_length = longint'(val);
            REG_TIME_STEP:  cfg_time_step = longint'(val);
            REG_GRAVITY:    cfg_gravity = longint'(val[15:0]);
            REG_ACCEL_GAIN: cfg_gain = longint'(val[15:0]);
            default: ;
        endcase
    endtask

    task automatic set_regs(input logic [31:0] il, input logic [31:0] dt,
                            input logic [31:0] g, input logic [31:0] k);
        write_reg(REG_INV_LENGTH, il);
        write_reg(REG_TIME_STEP, dt);
        write_reg(REG_GRAVITY, g);
        write_reg(REG_ACCEL_GAIN, k);
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic logic [31:0] random_accel();
        case ($urandom_range(0, 5))
            0, 1:    return $urandom();
            2:       return $urandom_range(0, 32'h000fffff) - 32'h00080000;
            3:       return $urandom_range(0, 32'h00ffffff) - 32'h00800000;
            4:       return 32'd0;
            default: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
        endcase
    endfunction

    task automatic queue_tick(input logic [31:0] ax, input logic [31:0] ay, input logic rs);
        t_tick_in t;
        t.accel_x = ax;
        t.accel_y = ay;
        t.restart = rs;
        tick_pending_q.insert(tick_pending_q.size(), t);
    endtask

    task automatic queue_random(input int n);
        for (int i = 0; i < n; i++)
            queue_tick(random_accel(), random_accel(), $urandom_range(0, 31) == 0);
    endtask

    task automatic wait_idle();
        while (tick_pending_q.size() > 0 || in_ch.valid || tick_expect_q.size() > 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    // Sequence of phases
    initial begin
        cfg_inv_length = longint'(INV_LENGTH_RST);
        cfg_time_step = longint'(TIME_STEP_RST);
        cfg_gravity = longint'(GRAVITY_RST);
        cfg_gain = longint'(ACCEL_GAIN_RST);
        reload_pendulum();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Defaults, plus a write to an unmapped index that must be ignored
        write_reg(REG_UNMAPPED, $urandom());
        set_regs(INV_LENGTH_RST, TIME_STEP_RST, {16'($urandom_range(0, 65535)), GRAVITY_RST},
                 {16'hffff, ACCEL_GAIN_RST});

        // Directed: field extremes and restarts
        queue_tick(32'd0, 32'd0, 1'b0);
        queue_tick(32'h7fffffff, 32'h7fffffff, 1'b0);
        queue_tick(32'h80000000, 32'h80000000, 1'b0);
        queue_tick(32'h7fffffff, 32'h80000000, 1'b0);
        queue_tick(32'hffffffff, 32'h00000001, 1'b0);
        queue_tick(32'h00010000, 32'hffff0000, 1'b0);
        queue_tick(32'h12345678, 32'h9abcdef0, 1'b1);
        queue_tick(32'hffffffff, 32'hffffffff, 1'b1);
        queue_tick(32'h00000000, 32'h00000000, 1'b0);
        queue_tick(32'h00100000, 32'h00000000, 1'b0);
        queue_tick(32'hfff00000, 32'h00000000, 1'b0);
        queue_tick(32'h80000000, 32'h7fffffff, 1'b0);
        wait_idle();

        // Large step and gain: angle and rate run into saturation, large angles
        set_regs(32'hffffffff, 32'hffffffff, 32'h0000ffff, 32'h0000ffff);
        queue_tick(32'h7fffffff, 32'h7fffffff, 1'b0);
        queue_tick(32'h80000000, 32'h80000000, 1'b0);
        queue_tick(32'h7fffffff, 32'h00000000, 1'b0);
        queue_tick(32'h00000000, 32'h80000000, 1'b0);
        queue_tick(32'h00000000, 32'h00000000, 1'b0);
        queue_tick(32'h00000000, 32'h00000000, 1'b1);
        queue_random(200);
        wait_idle();

        // Zero registers, steady flow with a long receiver hold-off
        set_regs(32'd0, 32'd0, 32'd0, 32'd0);
        steady_flow <= 1'b1;
        pressure_go <= 1'b1;
        queue_random(120);
        wait_idle();
        steady_flow <= 1'b0;

        // Defaults, random traffic
        set_regs(INV_LENGTH_RST, TIME_STEP_RST, GRAVITY_RST, ACCEL_GAIN_RST);
        queue_tick(32'd0, 32'd0, 1'b1);
        queue_random(300);
        wait_idle();

        // Random register settings
        for (int p = 0; p < 4; p++) begin
            set_regs($urandom(), $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 32'h0fffffff),
                     $urandom(), $urandom());
            queue_tick(32'd0, 32'd0, 1'b1);
            queue_random(170);
            wait_idle();
        end

        repeat (TICK_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && tick_expect_q.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #50000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
